### rtl/core/gaussian_blur_3x3_stream_defines.svh
// Assertion macros used by the port-level checker of the 3x3 blur stream.
// Every macro samples at the rising edge of i_clk of the scope that uses it.
`ifndef GAUSSIAN_BLUR_3X3_STREAM_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define GB3_ASSERT_NOW(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gb3 check failed");

// Next-cycle implication, off while reset is asserted.
`define GB3_ASSERT_NEXT(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gb3 check failed");

// Next-cycle implication that also runs through reset.
`define GB3_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gb3 check failed");

`endif

### rtl/core/gb3_pkg.sv
// Shared constants, register codes and a helper function of the 3x3 blur stream.
// No dependencies; used by the RTL and the checker.
package gb3_pkg;

    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
    localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PROD_W    = 2 * DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic OP_FLUSH = 1'b1;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > hi) begin
            res = DIM_W'(hi);
        end
        return res;
    endfunction

    localparam logic [DIM_W-1:0] RESET_WIDTH  = clamp_dim(DIM_W'(256), MAX_WIDTH);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = clamp_dim(DIM_W'(256), MAX_HEIGHT);
    localparam logic [CNT_W-1:0] RESET_AREA   =
        CNT_W'(PROD_W'(RESET_WIDTH) * PROD_W'(RESET_HEIGHT));

endpackage

### rtl/core/gaussian_blur_3x3_stream.sv
// 3x3 Gaussian blur over a raster stream of signed 8-bit pixels, zero-padded border,
// kernel 1 2 1 / 2 4 2 / 1 2 1, result = floor(sum / 16). Depends on gb3_pkg, gb3_ram.
//
// One item is taken per clock while o_stall is low. An item is read from the line memory
// in the cycle it is taken, combined with the window and written back in stage 1, and its
// result sits in the output register after that; one read and one write port of the line
// memory per cycle set this rate, with a bypass for back-to-back items on the same column
// (width 1). A frame is image_width*image_height pixels followed by image_width+1 flush
// items; the result for a pixel is formed by the item image_width+1 positions later and
// shows on o_valid once that item has passed stage 1. The last result of a frame
// carries o_frame_end. Writing either register restarts the frame. No clearing pass is
// needed after reset: line memory entries not yet written in the current frame only
// reach window taps above the first row or left of the first column, which read as zero.
module gaussian_blur_3x3_stream (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic signed [gb3_pkg::PIX_W-1:0]     i_pixel,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [gb3_pkg::PIX_W-1:0]     o_blurred,
    output logic                                 o_frame_end,
    input  logic                                 i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gb3_pkg::DIM_W-1:0]            i_cfg_data
);

    localparam int PIX_W = gb3_pkg::PIX_W;
    localparam int SUM_W = PIX_W + 4;
    localparam int LS_W  = 2 * PIX_W;

    typedef struct packed {
        logic                                emit;
        logic                                mask_left;
        logic                                mask_right;
        logic                                mask_top;
        logic                                fend;
        logic [gb3_pkg::COL_W-1:0]           col;
        logic signed [PIX_W-1:0]             pix;
    } t_s1;

    logic [gb3_pkg::DIM_W-1:0]  r_w, r_h, n_w, n_h;
    logic [gb3_pkg::CNT_W-1:0]  r_area, n_area;
    logic [gb3_pkg::COL_W-1:0]  r_col;
    logic [gb3_pkg::ROW_W-1:0]  r_row;
    logic [gb3_pkg::CNT_W-1:0]  r_cnt;

    logic                       r_s1_valid;
    t_s1                        r_s1, n_s1;
    logic                       r_fwd;
    logic [LS_W-1:0]            r_fwd_data;

    logic                       r_o_valid;
    logic signed [PIX_W-1:0]    r_o_blurred;
    logic                       r_o_fend;

    logic signed [PIX_W-1:0]    r_win [3][3];

    logic                       accept, s1_go;
    logic [gb3_pkg::COL_W-1:0]  col_eff;
    logic [31:0]                col_inc;
    logic                       wrap, rs_emit, in_emit, emit, fend;
    logic signed [PIX_W-1:0]    pix_v;

    logic [LS_W-1:0]            ram_rdata, ram_wdata, s1_line;
    logic signed [PIX_W-1:0]    s1_a, s1_b;
    logic signed [PIX_W-1:0]    new_col [3];
    logic signed [PIX_W-1:0]    g0, g1, g2;
    logic signed [SUM_W-1:0]    row_sum [3];
    logic signed [SUM_W-1:0]    sum;

    // configuration
    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (i_cfg_we && i_cfg_index == gb3_pkg::CFG_WIDTH) begin
            n_w = gb3_pkg::clamp_dim(i_cfg_data, gb3_pkg::MAX_WIDTH);
        end
        if (i_cfg_we && i_cfg_index == gb3_pkg::CFG_HEIGHT) begin
            n_h = gb3_pkg::clamp_dim(i_cfg_data, gb3_pkg::MAX_HEIGHT);
        end
        n_area = gb3_pkg::CNT_W'(gb3_pkg::PROD_W'(n_w) * gb3_pkg::PROD_W'(n_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= gb3_pkg::RESET_WIDTH;
            r_h    <= gb3_pkg::RESET_HEIGHT;
            r_area <= gb3_pkg::RESET_AREA;
        end else begin
            r_w    <= n_w;
            r_h    <= n_h;
            r_area <= n_area;
        end
    end

    // stage 0: position, emit decision, line memory read
    assign s1_go   = r_s1_valid && (!r_s1.emit || !r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        col_eff = (32'(r_col) >= 32'(r_w)) ? '0 : r_col;
        col_inc = 32'(col_eff) + 32'd1;
        wrap    = col_inc >= 32'(r_w);
        rs_emit = (col_eff == '0) && (32'(r_row) >= 32'd2);
        in_emit = (col_eff != '0) && (32'(r_row) >= 32'd1);
        emit    = rs_emit || in_emit;
        fend    = emit && ((32'(r_cnt) + 32'd1) >= 32'(r_area));
        pix_v   = (i_op == gb3_pkg::OP_FLUSH || 32'(r_row) >= 32'(r_h)) ? '0 : i_pixel;

        n_s1.emit       = emit;
        n_s1.mask_left  = rs_emit ? (32'(r_w) < 32'd2) : (32'(col_eff) == 32'd1);
        n_s1.mask_right = rs_emit;
        n_s1.mask_top   = rs_emit ? (32'(r_row) < 32'd3) : (32'(r_row) < 32'd2);
        n_s1.fend       = fend;
        n_s1.col        = col_eff;
        n_s1.pix        = pix_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (fend) begin
                r_col <= '0;
                r_row <= '0;
                r_cnt <= '0;
            end else begin
                r_col <= wrap ? '0 : gb3_pkg::COL_W'(col_inc);
                r_row <= wrap ? r_row + gb3_pkg::ROW_W'(1) : r_row;
                if (emit) begin
                    r_cnt <= r_cnt + gb3_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_s1;
            r_fwd      <= s1_go && (r_s1.col == col_eff);
            r_fwd_data <= ram_wdata;
        end
    end

    // line memory: upper byte previous row, lower byte the row before
    gb3_ram #(
        .WIDTH (LS_W),
        .DEPTH (gb3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1.col),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    // stage 1: window update, kernel, write back
    always_comb begin
        s1_line    = r_fwd ? r_fwd_data : ram_rdata;
        s1_a       = s1_line[LS_W-1:PIX_W];
        s1_b       = s1_line[PIX_W-1:0];
        ram_wdata  = {r_s1.pix, s1_a};
        new_col[0] = s1_b;
        new_col[1] = s1_a;
        new_col[2] = r_s1.pix;
        g0 = '0;
        g1 = '0;
        g2 = '0;
        for (int k = 0; k < 3; k++) begin
            g0 = r_s1.mask_left  ? '0 : r_win[k][1];
            g1 = r_win[k][2];
            g2 = r_s1.mask_right ? '0 : new_col[k];
            if (k == 0 && r_s1.mask_top) begin
                g0 = '0;
                g1 = '0;
                g2 = '0;
            end
            row_sum[k] = SUM_W'(g0) + (SUM_W'(g1) <<< 1) + SUM_W'(g2);
        end
        sum = row_sum[0] + (row_sum[1] <<< 1) + row_sum[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    r_win[k][m] <= '0;
                end
            end
        end else if (s1_go) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_s1.fend ? '0 : r_win[k][1];
                r_win[k][1] <= r_s1.fend ? '0 : r_win[k][2];
                r_win[k][2] <= r_s1.fend ? '0 : new_col[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && r_s1.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.emit) begin
            r_o_blurred <= sum[SUM_W-1:4];
            r_o_fend    <= r_s1.fend;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_blurred   = r_o_blurred;
    assign o_frame_end = r_o_fend;

endmodule

### rtl/core/gb3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/gb3_checker.sv
// Port-level checks of the 3x3 blur stream, bound to the top level.
// Depends on gb3_pkg and gaussian_blur_3x3_stream_defines.svh.
`include "gaussian_blur_3x3_stream_defines.svh"

module gb3_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              i_op,
    input logic signed [gb3_pkg::PIX_W-1:0]  i_pixel,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [gb3_pkg::PIX_W-1:0]  o_blurred,
    input logic                              o_frame_end,
    input logic                              i_cfg_we,
    input logic [gb3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [gb3_pkg::DIM_W-1:0]         i_cfg_data
);

    logic unused_in;
    logic [gb3_pkg::PIX_W:0] out_word;
    assign unused_in = i_valid ^ i_op ^ (^i_pixel) ^ i_cfg_we ^ (^i_cfg_index) ^ (^i_cfg_data);
    assign out_word  = {o_blurred, o_frame_end};

    `GB3_ASSERT_NEXT(a_out_hold, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))
    `GB3_ASSERT_NOW(a_stall_only_when_full, i_rst_n, o_stall, o_valid && i_stall)
    `GB3_ASSERT_NEXT_ALWAYS(a_reset_clears, !i_rst_n, !o_valid && !o_stall)

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (.*);

### sim/gaussian_blur_3x3_stream_checker.sv
// Scoreboard for the 3x3 blur stream: predicts each blurred pixel from the input
// transfers and register writes, and compares the output transfers. Depends on gb3_pkg.
module gaussian_blur_3x3_stream_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_op,
    input  logic signed [gb3_pkg::PIX_W-1:0]  i_pixel,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [gb3_pkg::PIX_W-1:0]  i_blurred,
    input  logic                              i_frame_end,
    input  logic                              i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gb3_pkg::DIM_W-1:0]         i_cfg_data,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_failures
);

    localparam int PIX_W      = gb3_pkg::PIX_W;
    localparam int DIM_W      = gb3_pkg::DIM_W;
    localparam int MAX_WIDTH  = gb3_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT;
    localparam int BLUR_MAX   = 127;
    localparam int BLUR_MIN   = -128;

    typedef struct packed {
        logic [PIX_W-1:0] blurred;
        logic             frame_end;
    } t_blur_result;

    t_blur_result            blur_expect_q[$];
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic signed [PIX_W-1:0] prev_row  [MAX_WIDTH];
    logic signed [PIX_W-1:0] older_row [MAX_WIDTH];
    logic signed [PIX_W-1:0] win [3][3];
    int                      tap [3][3];
    int                      col_pos;
    int                      row_pos;
    int                      emitted;
    int                      results_seen = 0;
    int                      fail_count = 0;

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
        foreach (win[k, m]) win[k][m] = '0;
    endtask

    task automatic reset_model();
        width_reg  = gb3_pkg::RESET_WIDTH;
        height_reg = gb3_pkg::RESET_HEIGHT;
        foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        restart_frame();
        blur_expect_q.delete();
    endtask

    function automatic int kernel_blur();
        int acc;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                acc += ((k == 1) ? 2 : 1) * ((m == 1) ? 2 : 1) * tap[k][m];
            end
        end
        acc = acc >>> 4;
        if (acc > BLUR_MAX) acc = BLUR_MAX;
        if (acc < BLUR_MIN) acc = BLUR_MIN;
        return acc;
    endfunction

    task automatic predict_blur(input logic op, input logic signed [PIX_W-1:0] pix);
        int           w;
        int           h;
        int           v;
        int           col;
        int           res;
        bit           emit;
        t_blur_result want;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        v = (op == gb3_pkg::OP_FLUSH || row_pos >= h) ? 0 : int'(pix);
        col = (col_pos >= w) ? 0 : col_pos;
        res = 0;
        emit = 1'b0;

        // row start: last pixel of the row two rows up
        if (col == 0 && row_pos >= 2) begin
            for (int k = 0; k < 3; k++) begin
                tap[k][0] = (w >= 2) ? win[k][1] : 0;
                tap[k][1] = win[k][2];
                tap[k][2] = 0;
            end
            if (row_pos < 3) begin
                tap[0][0] = 0;
                tap[0][1] = 0;
            end
            res = kernel_blur();
            emit = 1'b1;
        end

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = older_row[col];
        win[1][2] = prev_row[col];
        win[2][2] = PIX_W'(v);
        older_row[col] = prev_row[col];
        prev_row[col]  = PIX_W'(v);

        if (col >= 1 && row_pos >= 1) begin
            foreach (tap[k, m]) tap[k][m] = win[k][m];
            if (col == 1) begin
                for (int k = 0; k < 3; k++) tap[k][0] = 0;
            end
            if (row_pos < 2) begin
                for (int m = 0; m < 3; m++) tap[0][m] = 0;
            end
            res = kernel_blur();
            emit = 1'b1;
        end

        col++;
        if (col >= w) begin
            col = 0;
            row_pos++;
        end
        col_pos = col;

        if (emit) begin
            emitted++;
            want.blurred   = PIX_W'(res);
            want.frame_end = (emitted >= w * h);
            blur_expect_q.push_back(want);
            if (want.frame_end) restart_frame();
        end
    endtask

    task automatic check_blur();
        t_blur_result want;
        results_seen++;
        if (blur_expect_q.size() == 0) begin
            $error("blurred result %0d with no pixel waiting for it", i_blurred);
            fail_count++;
        end else begin
            want = blur_expect_q.pop_front();
            if (i_blurred !== want.blurred) begin
                $error("blurred: expected %0d, actual %0d", $signed(want.blurred), i_blurred);
                fail_count++;
            end
            if (i_frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, i_frame_end);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gb3_pkg::CFG_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
                restart_frame();
            end
            if (i_in_valid && !i_in_stall) predict_blur(i_op, i_pixel);
            if (i_out_valid && !i_out_stall) check_blur();
        end
        o_pending  <= blur_expect_q.size();
        o_results  <= results_seen;
        o_failures <= fail_count;
    end

endmodule

### sim/gaussian_blur_3x3_stream_tb.sv
// Top of the 3x3 blur stream testbench: clock, reset, frame stimulus, idle and stall
// patterns and the verdict. Depends on gb3_pkg, the block and its checker.
module gaussian_blur_3x3_stream_tb;

    localparam int PIX_W      = gb3_pkg::PIX_W;
    localparam int DIM_W      = gb3_pkg::DIM_W;
    localparam int CFG_IDX_W  = gb3_pkg::CFG_IDX_W;
    localparam int MAX_WIDTH  = gb3_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ITEMS    = 30;
    localparam int WIDE_CUT        = 270;
    localparam int BUSY_PCT        = 74;
    localparam int LIGHT_PCT       = 6;

    localparam logic                    OP_PIXEL = 1'b0;
    localparam logic signed [PIX_W-1:0] PIX_MAX  = 8'sd127;
    localparam logic signed [PIX_W-1:0] PIX_MIN  = 8'sh80;
    localparam logic signed [PIX_W-1:0] PIX_ZERO = 8'sd0;
    localparam logic signed [PIX_W-1:0] PIX_NEG1 = -8'sd1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH_LIGHT
    } t_idle_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_op = OP_PIXEL;
    logic signed [PIX_W-1:0] i_pixel = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [PIX_W-1:0] o_blurred;
    logic                    o_frame_end;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = gb3_pkg::CFG_WIDTH;
    logic [DIM_W-1:0]        i_cfg_data = '0;

    int expected_pending;
    int results_checked;
    int failure_count;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off_req = 1'b0;
    int frame_w = MAX_WIDTH;
    int frame_h = MAX_HEIGHT;
    int items_sent = 0;
    int settings_run = 0;

    always #5 i_clk = ~i_clk;

    gaussian_blur_3x3_stream u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_blurred   (o_blurred),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gaussian_blur_3x3_stream_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_blurred   (o_blurred),
        .i_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (expected_pending),
        .o_results   (results_checked),
        .o_failures  (failure_count)
    );

    function automatic int dim_in_effect(logic [DIM_W-1:0] raw, int bound);
        if (raw == '0) return 1;
        if (int'(raw) > bound) return bound;
        return int'(raw);
    endfunction

    function automatic logic signed [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return PIX_MAX;
            1: return PIX_MIN;
            2: return PIX_ZERO;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int frame_len();
        return frame_w * frame_h + frame_w + 1;
    endfunction

    task automatic send_transfer(input logic op, input logic signed [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_pixel <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int w_raw, input int h_raw, input t_idle_mode mode);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gb3_pkg::CFG_WIDTH;
        i_cfg_data  <= DIM_W'(w_raw);
        @(posedge i_clk);
        i_cfg_index <= gb3_pkg::CFG_HEIGHT;
        i_cfg_data  <= DIM_W'(h_raw);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_w = dim_in_effect(DIM_W'(w_raw), MAX_WIDTH);
        frame_h = dim_in_effect(DIM_W'(h_raw), MAX_HEIGHT);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                stall_pct <= 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = BUSY_PCT;
                stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                stall_pct <= BUSY_PCT;
            end
            default: begin
                sender_idle_pct = LIGHT_PCT;
                stall_pct <= LIGHT_PCT;
            end
        endcase
        settings_run++;
    endtask

    task automatic send_frame(input int cut, input bit fixed,
                              input logic signed [PIX_W-1:0] fill);
        int                      area;
        logic                    op;
        logic signed [PIX_W-1:0] pix;
        area = frame_w * frame_h;
        for (int n = 0; n < cut; n++) begin
            if (fixed) begin
                op  = (n == area / 2) ? gb3_pkg::OP_FLUSH : OP_PIXEL;
                pix = fill;
            end else if (n < area) begin
                op  = ($urandom_range(0, 15) == 0) ? gb3_pkg::OP_FLUSH : OP_PIXEL;
                pix = random_pixel();
            end else begin
                op  = $urandom_range(0, 1) ? gb3_pkg::OP_FLUSH : OP_PIXEL;
                pix = random_pixel();
            end
            send_transfer(op, pix);
        end
    endtask

    task automatic run_phase(input int w_raw, input int h_raw,
                             input t_idle_mode mode, input int frames,
                             input bit abort_last, input bit hold_off);
        int len;
        configure(w_raw, h_raw, mode);
        if (hold_off) hold_off_req <= 1'b1;
        len = frame_len();
        for (int f = 0; f < frames; f++) begin
            if (abort_last && f == frames - 1) begin
                send_frame($urandom_range(1, len - 1), 1'b0, PIX_ZERO);
            end else begin
                send_frame(len, 1'b0, PIX_ZERO);
            end
        end
    endtask

    initial begin : receiver
        bit served = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !served) begin
                served = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[gaussian_blur_3x3_stream] ERROR");
        $finish;
    end

    initial begin : stimulus
        int random_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // row 0 at the reset size, dropped by the first register write
        send_transfer(OP_PIXEL, PIX_MAX);
        send_transfer(OP_PIXEL, PIX_MIN);
        send_transfer(OP_PIXEL, PIX_ZERO);
        send_transfer(OP_PIXEL, PIX_NEG1);
        send_transfer(gb3_pkg::OP_FLUSH, PIX_MAX);

        configure(3, 3, IDLE_NONE);
        send_frame(frame_len(), 1'b1, PIX_MAX);
        configure(3, 2, IDLE_RECEIVER);
        send_frame(frame_len(), 1'b1, PIX_MIN);

        run_phase(0, 0, IDLE_SENDER, 3, 1'b0, 1'b0);
        run_phase(1, 7, IDLE_RECEIVER, 2, 1'b0, 1'b0);
        run_phase(2, 3, IDLE_BOTH_LIGHT, 2, 1'b0, 1'b0);

        // clamp the width, stop a few pixels into the second row
        configure(511, 1, IDLE_NONE);
        send_frame(WIDE_CUT, 1'b0, PIX_ZERO);

        run_phase(1, 511, IDLE_NONE, 1, 1'b0, 1'b0);
        run_phase(16, 3, IDLE_NONE, 1, 1'b0, 1'b1);
        run_phase(6, 6, IDLE_BOTH_LIGHT, 2, 1'b1, 1'b0);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            run_phase($urandom_range(0, 12), $urandom_range(0, 8),
                      t_idle_mode'($urandom_range(0, 3)), $urandom_range(1, 2),
                      $urandom_range(0, 5) == 0, 1'b0);
        end
        wait_until_drained();

        $display("Sent %0d pixel and flush transfers over %0d image sizes, checked %0d results,",
                 items_sent, settings_run, results_checked);
        $display("with idle/stall phases and one %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        if (failure_count == 0) begin
            $display("[gaussian_blur_3x3_stream] OK");
        end else begin
            $display("[gaussian_blur_3x3_stream] ERROR");
        end
        $finish;
    end

endmodule
